>>> rtl/rfus_pkg.sv
// Package for the ring FIFO with usage statistics.
// Holds the command, status and state codes, shared widths and the
// controller-to-datapath command struct. No dependencies.
package rfus_pkg;

    // Fixed field widths
    localparam int CMD_W          = 2;
    localparam int WORD_W         = 32;
    localparam int CAP_W          = 9;
    localparam int CNT_W          = 16;
    localparam int CAP_MAX        = 511;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 256;
    localparam int ITEM_BYTES_DEF = 4;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_TAKE  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NODATA   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;   // capture the incoming item
        logic exec;    // carry out the captured command
    } t_dp_ctrl;

endpackage

>>> rtl/rfus_ctrl.sv
// Controller for the ring FIFO: handshake state machine.
// Depends on rfus_pkg.
module rfus_ctrl
    import rfus_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_strobe,
    output t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                // a new item may be taken while the result is shown
                n_state = start ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        busy         = 1'b0;
        o_strobe     = 1'b0;
        o_ctrl.exec  = 1'b0;
        case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                busy        = 1'b1;
                o_ctrl.exec = 1'b1;
            end
            S_RESP: begin
                o_strobe = 1'b1;
            end
            default: begin
            end
        endcase
        o_ctrl.latch = start && !busy;
    end

endmodule

>>> rtl/rfus_datapath.sv
// Datapath for the ring FIFO: item store, pointers, flags and statistics.
// Depends on rfus_pkg.
module rfus_datapath
    import rfus_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_BYTES = ITEM_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctrl          i_ctrl,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [WORD_W-1:0] i_write_data,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    output logic [1:0]        o_status,
    output logic [WORD_W-1:0] o_read_data,
    output logic              o_is_empty,
    output logic              o_is_full,
    output logic [CAP_W-1:0]  o_occupancy,
    output logic [CAP_W-1:0]  o_high_water,
    output logic [CNT_W-1:0]  o_puts_done,
    output logic [CNT_W-1:0]  o_takes_done
);

    // Capacity never exceeds CAP_MAX, so slots past that are never used
    localparam int MEM_DEPTH = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
    localparam int PTR_W     = $clog2(MEM_DEPTH);
    localparam int ITEM_W    = 8 * ITEM_BYTES;
    localparam int DW        = (ITEM_W < WORD_W) ? ITEM_W : WORD_W;

    logic [DW-1:0]     mem [MEM_DEPTH];
    logic [DW-1:0]     r_mem_q;

    logic [CMD_W-1:0]  r_cmd;
    logic [DW-1:0]     r_wdata;
    logic [CAP_W-1:0]  r_capacity;
    logic [PTR_W-1:0]  r_rd_slot;
    logic [PTR_W-1:0]  r_wr_slot;
    logic              r_full;
    logic              r_empty;
    logic [CAP_W-1:0]  r_held;
    logic [CAP_W-1:0]  r_peak;
    logic [CNT_W-1:0]  r_puts;
    logic [CNT_W-1:0]  r_takes;
    t_status           r_status;
    logic              r_take_ok;

    logic [CAP_W-1:0]  cap_eff;
    logic [PTR_W-1:0]  n_wr_slot;
    logic [PTR_W-1:0]  n_rd_slot;
    logic [CAP_W-1:0]  held_inc;
    logic              put_ok;
    logic              take_ok;

    // Effective capacity: zero acts as one, clamp to the store depth
    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CAP_W'(1);
        end else if (32'(r_capacity) > MEM_DEPTH) begin
            cap_eff = CAP_W'(MEM_DEPTH);
        end else begin
            cap_eff = r_capacity;
        end
    end

    // Pointer advance with wrap at the capacity
    always_comb begin
        if ((10'(r_wr_slot) + 10'd1) == 10'(cap_eff)) begin
            n_wr_slot = '0;
        end else begin
            n_wr_slot = r_wr_slot + PTR_W'(1);
        end
        if ((10'(r_rd_slot) + 10'd1) == 10'(cap_eff)) begin
            n_rd_slot = '0;
        end else begin
            n_rd_slot = r_rd_slot + PTR_W'(1);
        end
    end

    assign held_inc = r_held + CAP_W'(1);
    assign put_ok   = i_ctrl.exec && (t_cmd'(r_cmd) == CMD_PUT)  && !r_full;
    assign take_ok  = i_ctrl.exec && (t_cmd'(r_cmd) == CMD_TAKE) && !r_empty;

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_cmd   <= i_command;
            r_wdata <= i_write_data[DW-1:0];
        end
    end

    // Item store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (put_ok) begin
            mem[r_wr_slot] <= r_wdata;
        end
        if (take_ok) begin
            r_mem_q <= mem[r_rd_slot];
        end
    end

    // Result status and read qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= ST_OK;
            r_take_ok <= 1'b0;
        end else if (i_ctrl.exec) begin
            r_take_ok <= take_ok;
            r_status  <= ST_OK;
            case (t_cmd'(r_cmd))
                CMD_PUT:  if (r_full)  r_status <= ST_OVERFLOW;
                CMD_TAKE: if (r_empty) r_status <= ST_NODATA;
                default:  r_status <= ST_OK;
            endcase
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Pointers, flags and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we ||
            (i_ctrl.exec && (t_cmd'(r_cmd) == CMD_CLEAR))) begin
            r_rd_slot <= '0;
            r_wr_slot <= '0;
            r_full    <= 1'b0;
            r_empty   <= 1'b1;
            r_held    <= '0;
            r_peak    <= '0;
            r_puts    <= '0;
            r_takes   <= '0;
        end else if (put_ok) begin
            r_wr_slot <= n_wr_slot;
            r_empty   <= 1'b0;
            r_full    <= (n_wr_slot == r_rd_slot);
            r_held    <= held_inc;
            if (held_inc > r_peak) r_peak <= held_inc;
            r_puts    <= r_puts + CNT_W'(1);
        end else if (take_ok) begin
            r_rd_slot <= n_rd_slot;
            r_full    <= 1'b0;
            r_empty   <= (n_rd_slot == r_wr_slot);
            if (r_held != '0) r_held <= r_held - CAP_W'(1);
            r_takes   <= r_takes + CNT_W'(1);
        end
    end

    // Result fields
    assign o_status     = r_status;
    assign o_read_data  = r_take_ok ? WORD_W'(r_mem_q) : '0;
    assign o_is_empty   = r_empty;
    assign o_is_full    = r_full;
    assign o_occupancy  = r_held;
    assign o_high_water = r_peak;
    assign o_puts_done  = r_puts;
    assign o_takes_done = r_takes;

endmodule

>>> rtl/ring_fifo_with_usage_stats_top.sv
// Ring FIFO with usage statistics, top level; uses rfus_pkg, rfus_ctrl and rfus_datapath.
// An item is accepted when start is high and busy low; the controller then passes
// through S_EXEC, and o_strobe marks its result for the one cycle it spends in S_RESP.
// busy covers the store access and state update; the next item may be accepted
// while the result is shown. The receiver cannot stall.
// Synchronous active-low reset empties the FIFO, zeroes statistics, capacity 256.
module ring_fifo_with_usage_stats_top
    import rfus_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_BYTES = ITEM_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [WORD_W-1:0] i_write_data,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic [WORD_W-1:0] o_read_data,
    output logic              o_is_empty,
    output logic              o_is_full,
    output logic [CAP_W-1:0]  o_occupancy,
    output logic [CAP_W-1:0]  o_high_water,
    output logic [CNT_W-1:0]  o_puts_done,
    output logic [CNT_W-1:0]  o_takes_done
);

    t_dp_ctrl ctrl;

    // Handshake controller
    rfus_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_ctrl   (ctrl)
    );

    // Store and statistics
    rfus_datapath #(
        .DEPTH      (DEPTH),
        .ITEM_BYTES (ITEM_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_command    (i_command),
        .i_write_data (i_write_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_status     (o_status),
        .o_read_data  (o_read_data),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .o_occupancy  (o_occupancy),
        .o_high_water (o_high_water),
        .o_puts_done  (o_puts_done),
        .o_takes_done (o_takes_done)
    );

endmodule
